// ----- hdl/edf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types, constants and helpers of the EDF task scheduler.
// ----------------------------------------------------------------------------
package edf_pkg;

   localparam int TASKS     = 16;
   localparam int TIME_BITS = 24;
   localparam int ID_W      = $clog2(TASKS);

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_DISP  = 2'd1;
   localparam logic [1:0] KIND_BLOCK = 2'd2;
   localparam logic [1:0] KIND_TICK  = 2'd3;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READY = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;
   localparam logic [1:0] ST_BLOCK = 2'd3;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LATCH,
      OP_ADD,
      OP_DISP,
      OP_BLOCK,
      OP_UNBLK,
      OP_MISS_A,
      OP_MISS_B,
      OP_BEST,
      OP_PREEMPT,
      OP_START,
      OP_CHG_A,
      OP_CHG_B
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [ID_W-1:0]   idx;
   } dp_cmd_type;

   typedef struct packed {
      logic id_ok;
      logic none;
   } dp_sts_type;

   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
   endfunction

endpackage

// ----- hdl/edf_task_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_task_scheduler
// Preemptive earliest-deadline-first scheduler over a table of tasks.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken on a rising edge with start high and busy low; the req_
//   ports carry add, dispatch, block or tick. busy stays high until the
//   result has gone out. Exactly one result word per request appears on the
//   rsp_ ports for one cycle, marked by rsp_valid; the receiver cannot stall.
// Steps per request; the best-deadline scan takes one table entry per cycle:
//   block     table write of the blocked state
//   add       table write, best-deadline scan, preempt check
//   dispatch  best-deadline scan and start, skipped when nothing is ready
//   tick      unblock step, miss scan (check, then deadline update, per entry),
//             best scan, preempt check, budget charge
//   One word at a time; the next may start the cycle after rsp_valid.
// Reset: synchronous, active high. All tasks idle, nothing ready or
//   running. Timing entries of a task hold no value until it is added.
// ----------------------------------------------------------------------------
module edf_task_scheduler import edf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_task_id,
   input  logic        req_task_valid,
   input  logic [15:0] req_period,
   input  logic [15:0] req_budget,
   input  logic [23:0] req_arrival_time,
   input  logic [23:0] req_deadline,
   input  logic [23:0] req_current_time,
   input  logic        req_syscall_done,
   input  logic [1:0]  req_block_ticks,
   output logic        rsp_valid,
   output logic        rsp_running_valid,
   output logic [3:0]  rsp_running_id,
   output logic        rsp_none_ready,
   output logic        rsp_preempted,
   output logic        rsp_unblocked,
   output logic [15:0] rsp_missed_mask,
   output logic        rsp_completed,
   output logic [3:0]  rsp_completed_id,
   output logic [23:0] rsp_next_arrival,
   output logic [23:0] rsp_next_deadline
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   edf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_kind),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   edf_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_task_id       (req_task_id),
      .req_task_valid    (req_task_valid),
      .req_period        (req_period),
      .req_budget        (req_budget),
      .req_arrival_time  (req_arrival_time),
      .req_deadline      (req_deadline),
      .req_current_time  (req_current_time),
      .req_syscall_done  (req_syscall_done),
      .req_block_ticks   (req_block_ticks),
      .rsp_running_valid (rsp_running_valid),
      .rsp_running_id    (rsp_running_id),
      .rsp_none_ready    (rsp_none_ready),
      .rsp_preempted     (rsp_preempted),
      .rsp_unblocked     (rsp_unblocked),
      .rsp_missed_mask   (rsp_missed_mask),
      .rsp_completed     (rsp_completed),
      .rsp_completed_id  (rsp_completed_id),
      .rsp_next_arrival  (rsp_next_arrival),
      .rsp_next_deadline (rsp_next_deadline)
   );

endmodule

// ----- hdl/edf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_ctrl
// Sequencer: walks each word through its steps and the task table scans.
// ----------------------------------------------------------------------------
module edf_ctrl import edf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  req_kind,
   input  dp_sts_type  sts,
   output dp_cmd_type  cmd,
   output logic        busy,
   output logic        rsp_valid
);

   typedef enum logic [3:0] {
      S_IDLE, S_ADD, S_DISP, S_BLOCK, S_UNBLK, S_MISS_A, S_MISS_B,
      S_BEST, S_PREEMPT, S_START, S_CHG_A, S_CHG_B, S_DONE
   } state_type;

   state_type       state_ff;
   logic [1:0]      kind_ff;
   logic [ID_W-1:0] idx_ff;
   logic            last;

   assign last      = (idx_ff == ID_W'(TASKS - 1));
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   always_comb begin
      cmd.idx = idx_ff;
      unique case (state_ff)
         S_IDLE:    cmd.op = start ? OP_LATCH : OP_NOP;
         S_ADD:     cmd.op = OP_ADD;
         S_DISP:    cmd.op = OP_DISP;
         S_BLOCK:   cmd.op = OP_BLOCK;
         S_UNBLK:   cmd.op = OP_UNBLK;
         S_MISS_A:  cmd.op = OP_MISS_A;
         S_MISS_B:  cmd.op = OP_MISS_B;
         S_BEST:    cmd.op = OP_BEST;
         S_PREEMPT: cmd.op = OP_PREEMPT;
         S_START:   cmd.op = OP_START;
         S_CHG_A:   cmd.op = OP_CHG_A;
         S_CHG_B:   cmd.op = OP_CHG_B;
         default:   cmd.op = OP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= KIND_ADD;
         idx_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  kind_ff <= req_kind;
                  idx_ff  <= '0;
                  unique case (req_kind)
                     KIND_ADD:   state_ff <= S_ADD;
                     KIND_DISP:  state_ff <= S_DISP;
                     KIND_BLOCK: state_ff <= S_BLOCK;
                     default:    state_ff <= S_UNBLK;
                  endcase
               end
            end
            S_ADD:    state_ff <= sts.id_ok ? S_BEST : S_DONE;
            S_DISP:   state_ff <= sts.none ? S_DONE : S_BEST;
            S_BLOCK:  state_ff <= S_DONE;
            S_UNBLK:  state_ff <= S_MISS_A;
            S_MISS_A: state_ff <= S_MISS_B;
            S_MISS_B: begin
               if (last) begin
                  idx_ff   <= '0;
                  state_ff <= S_BEST;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_MISS_A;
               end
            end
            S_BEST: begin
               if (last) begin
                  idx_ff   <= '0;
                  state_ff <= (kind_ff == KIND_DISP) ? S_START : S_PREEMPT;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_PREEMPT: state_ff <= (kind_ff == KIND_TICK) ? S_CHG_A : S_DONE;
            S_START:   state_ff <= S_DONE;
            S_CHG_A:   state_ff <= S_CHG_B;
            S_CHG_B:   state_ff <= S_DONE;
            default:   state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- hdl/edf_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_dpath
// Task table, ready set, running task and result registers.
// ----------------------------------------------------------------------------
module edf_dpath import edf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_sts_type  sts,
   input  logic [3:0]  req_task_id,
   input  logic        req_task_valid,
   input  logic [15:0] req_period,
   input  logic [15:0] req_budget,
   input  logic [23:0] req_arrival_time,
   input  logic [23:0] req_deadline,
   input  logic [23:0] req_current_time,
   input  logic        req_syscall_done,
   input  logic [1:0]  req_block_ticks,
   output logic        rsp_running_valid,
   output logic [3:0]  rsp_running_id,
   output logic        rsp_none_ready,
   output logic        rsp_preempted,
   output logic        rsp_unblocked,
   output logic [15:0] rsp_missed_mask,
   output logic        rsp_completed,
   output logic [3:0]  rsp_completed_id,
   output logic [23:0] rsp_next_arrival,
   output logic [23:0] rsp_next_deadline
);

   // latched request word
   logic [3:0]           id_ff;
   logic                 tvalid_ff;
   logic [15:0]          period_ff;
   logic [15:0]          budget_ff;
   logic [23:0]          arrival_ff;
   logic [23:0]          deadline_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic                 sys_ff;
   logic [1:0]           bticks_ff;

   // task table
   logic [TIME_BITS-1:0] dl_ff  [TASKS];
   logic [TIME_BITS-1:0] arr_ff [TASKS];
   logic [15:0]          per_ff [TASKS];
   logic [15:0]          bud_ff [TASKS];
   logic [15:0]          rem_ff [TASKS];
   logic [1:0]           cd_ff  [TASKS];
   logic [1:0]           st_ff  [TASKS];

   logic [TASKS-1:0]     ready_ff;
   logic                 busy_ff;
   logic [ID_W-1:0]      cur_ff;

   logic                 bv_ff;
   logic [ID_W-1:0]      best_id_ff;
   logic [TIME_BITS-1:0] best_dl_ff;
   logic [TIME_BITS-1:0] best_arr_ff;
   logic                 hit_ff;

   logic                 none_ff;
   logic                 pre_ff;
   logic                 unb_ff;
   logic [15:0]          miss_ff;
   logic                 comp_ff;
   logic [3:0]           comp_id_ff;
   logic [TIME_BITS-1:0] narr_ff;
   logic [TIME_BITS-1:0] ndl_ff;

   logic [ID_W-1:0]      a;
   logic                 id_ok;
   logic [TIME_BITS-1:0] r_dl;
   logic [TIME_BITS-1:0] r_arr;
   logic [TIME_BITS-1:0] r_per;
   logic [15:0]          r_rem;
   logic [15:0]          rem_dec;
   logic [TIME_BITS-1:0] sum_ap;
   logic [TIME_BITS-1:0] sum_np;
   logic                 better;

   assign id_ok     = (32'(id_ff) < TASKS);
   assign sts.id_ok = id_ok;
   assign sts.none  = (ready_ff == '0) && !busy_ff;

   always_comb begin
      unique case (cmd.op)
         OP_ADD, OP_BLOCK, OP_UNBLK:      a = ID_W'(id_ff);
         OP_PREEMPT, OP_CHG_A, OP_CHG_B:  a = cur_ff;
         default:                         a = cmd.idx;
      endcase
   end

   assign r_dl    = dl_ff[a];
   assign r_arr   = arr_ff[a];
   assign r_per   = TIME_BITS'(per_ff[a]);
   assign r_rem   = rem_ff[a];
   assign rem_dec = (r_rem == '0) ? '0 : r_rem - 1'b1;
   assign sum_ap  = sat_add(r_arr, r_per);
   assign sum_np  = sat_add(now_ff, r_per);
   // scan runs in ascending id, so a full tie keeps the earlier one
   assign better  = (r_dl < best_dl_ff) ||
                    ((r_dl == best_dl_ff) && (r_arr < best_arr_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASKS; i++) st_ff[i] <= ST_IDLE;
         ready_ff <= '0;
         busy_ff  <= 1'b0;
         cur_ff   <= '0;
         bv_ff    <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         unique case (cmd.op)
            OP_ADD: begin
               if (busy_ff && cur_ff == a) busy_ff <= 1'b0;
               per_ff[a]   <= period_ff;
               bud_ff[a]   <= budget_ff;
               rem_ff[a]   <= budget_ff;
               arr_ff[a]   <= TIME_BITS'(arrival_ff);
               dl_ff[a]    <= TIME_BITS'(deadline_ff);
               st_ff[a]    <= ST_READY;
               ready_ff[a] <= 1'b1;
            end
            OP_DISP: begin
               if (!sts.none && busy_ff) begin
                  ready_ff[cur_ff] <= 1'b1;
                  st_ff[cur_ff]    <= ST_READY;
               end
            end
            OP_BLOCK: begin
               if (id_ok) begin
                  st_ff[a]    <= ST_BLOCK;
                  cd_ff[a]    <= bticks_ff;
                  ready_ff[a] <= 1'b0;
                  if (busy_ff && cur_ff == a) busy_ff <= 1'b0;
               end
            end
            OP_UNBLK: begin
               if (tvalid_ff && id_ok && st_ff[a] == ST_BLOCK) begin
                  if (cd_ff[a] == '0) begin
                     st_ff[a]    <= ST_READY;
                     ready_ff[a] <= 1'b1;
                  end else begin
                     cd_ff[a] <= cd_ff[a] - 1'b1;
                  end
               end
            end
            OP_MISS_A: begin
               hit_ff <= ready_ff[a] && (r_dl < now_ff);
               if (ready_ff[a] && (r_dl < now_ff)) begin
                  arr_ff[a] <= sum_ap;
                  rem_ff[a] <= bud_ff[a];
               end
            end
            OP_MISS_B: begin
               if (hit_ff) dl_ff[a] <= sum_ap;
            end
            OP_BEST: begin
               if (ready_ff[a] && (cmd.idx == '0 || !bv_ff || better)) begin
                  bv_ff       <= 1'b1;
                  best_id_ff  <= a;
                  best_dl_ff  <= r_dl;
                  best_arr_ff <= r_arr;
               end else if (cmd.idx == '0) begin
                  bv_ff <= 1'b0;
               end
            end
            OP_PREEMPT: begin
               if (busy_ff && bv_ff && best_dl_ff < r_dl) begin
                  ready_ff[cur_ff]     <= 1'b1;
                  st_ff[cur_ff]        <= ST_READY;
                  ready_ff[best_id_ff] <= 1'b0;
                  st_ff[best_id_ff]    <= ST_RUN;
                  cur_ff               <= best_id_ff;
               end
            end
            OP_START: begin
               if (bv_ff) begin
                  ready_ff[best_id_ff] <= 1'b0;
                  st_ff[best_id_ff]    <= ST_RUN;
                  busy_ff              <= 1'b1;
                  cur_ff               <= best_id_ff;
               end
            end
            OP_CHG_A: begin
               hit_ff <= busy_ff && (rem_dec == '0 || sys_ff);
               if (busy_ff) begin
                  if (rem_dec == '0 || sys_ff) begin
                     st_ff[a]  <= ST_IDLE;
                     rem_ff[a] <= bud_ff[a];
                     arr_ff[a] <= sum_np;
                     busy_ff   <= 1'b0;
                  end else begin
                     rem_ff[a] <= rem_dec;
                  end
               end
            end
            OP_CHG_B: begin
               if (hit_ff) dl_ff[a] <= sum_ap;
            end
            default: ;
         endcase
      end
   end

   // request latch and result flags
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LATCH) begin
         id_ff       <= req_task_id;
         tvalid_ff   <= req_task_valid;
         period_ff   <= req_period;
         budget_ff   <= req_budget;
         arrival_ff  <= req_arrival_time;
         deadline_ff <= req_deadline;
         now_ff      <= TIME_BITS'(req_current_time);
         sys_ff      <= req_syscall_done;
         bticks_ff   <= req_block_ticks;
         none_ff     <= 1'b0;
         pre_ff      <= 1'b0;
         unb_ff      <= 1'b0;
         miss_ff     <= '0;
         comp_ff     <= 1'b0;
         comp_id_ff  <= '0;
         narr_ff     <= '0;
         ndl_ff      <= '0;
      end
      if (cmd.op == OP_DISP && sts.none) none_ff <= 1'b1;
      if (cmd.op == OP_PREEMPT && busy_ff && bv_ff && best_dl_ff < r_dl) pre_ff <= 1'b1;
      if (cmd.op == OP_UNBLK && tvalid_ff && id_ok && st_ff[a] == ST_BLOCK &&
          cd_ff[a] == '0) unb_ff <= 1'b1;
      if (cmd.op == OP_MISS_A && ready_ff[a] && (r_dl < now_ff))
         miss_ff <= miss_ff | (16'd1 << a);
      if (cmd.op == OP_CHG_A && busy_ff && (rem_dec == '0 || sys_ff)) begin
         comp_ff    <= 1'b1;
         comp_id_ff <= 4'(a);
         narr_ff    <= sum_np;
      end
      if (cmd.op == OP_CHG_B && hit_ff) ndl_ff <= sum_ap;
   end

   assign rsp_running_valid = busy_ff;
   assign rsp_running_id    = busy_ff ? 4'(cur_ff) : 4'd0;
   assign rsp_none_ready    = none_ff;
   assign rsp_preempted     = pre_ff;
   assign rsp_unblocked     = unb_ff;
   assign rsp_missed_mask   = miss_ff;
   assign rsp_completed     = comp_ff;
   assign rsp_completed_id  = comp_id_ff;
   assign rsp_next_arrival  = 24'(narr_ff);
   assign rsp_next_deadline = 24'(ndl_ff);

endmodule

// ----- hdl/edf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module edf_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_running_valid,
   input logic [3:0]  rsp_running_id,
   input logic        rsp_completed,
   input logic [3:0]  rsp_completed_id,
   input logic [23:0] rsp_next_arrival,
   input logic [23:0] rsp_next_deadline
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted word");

   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result word outside busy window");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle");

   a_idle_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_running_valid) |-> (rsp_running_id == 4'd0))
      else $error("running id set with no running task");

   a_no_comp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_completed) |->
         (rsp_completed_id == 4'd0 && rsp_next_arrival == 24'd0 &&
          rsp_next_deadline == 24'd0))
      else $error("completion fields set without completion");

endmodule

bind edf_task_scheduler edf_checker u_edf_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_running_valid (rsp_running_valid),
   .rsp_running_id    (rsp_running_id),
   .rsp_completed     (rsp_completed),
   .rsp_completed_id  (rsp_completed_id),
   .rsp_next_arrival  (rsp_next_arrival),
   .rsp_next_deadline (rsp_next_deadline)
);

// ----- tb/sv/tb_edf_task_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edf_task_scheduler
// Self-checking bench for the EDF scheduler: directed and random add,
// dispatch, block and tick words against a behavioral task-table predictor.
// ----------------------------------------------------------------------------
module tb_edf_task_scheduler;
   import edf_pkg::*;

   typedef struct packed {
      logic        running_valid;
      logic [3:0]  running_id;
      logic        none_ready;
      logic        preempted;
      logic        unblocked;
      logic [15:0] missed_mask;
      logic        completed;
      logic [3:0]  completed_id;
      logic [23:0] next_arrival;
      logic [23:0] next_deadline;
   } sched_out_type;

   // Scoreboard: predicts scheduler outputs and holds them until they arrive.
   class sched_board;
      logic [1:0]    status [16];
      logic [23:0]   dl [16];
      logic [23:0]   arr [16];
      logic [15:0]   per [16];
      logic [15:0]   bud [16];
      logic [15:0]   rem [16];
      logic [1:0]    cnt [16];
      logic [15:0]   ready;
      logic          cpu;
      logic [3:0]    cur;
      sched_out_type pending [$];
      int            errors;

      function new();
         for (int i = 0; i < 16; i++) begin
            status[i] = ST_IDLE; dl[i] = 0; arr[i] = 0; per[i] = 0;
            bud[i] = 0; rem[i] = 0; cnt[i] = 0;
         end
         ready = 0; cpu = 0; cur = 0; errors = 0;
      endfunction

      function logic [23:0] tsum(logic [23:0] a, logic [23:0] b);
         logic [24:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[24] ? 24'hFFFFFF : s[23:0];
      endfunction

      function bit earlier(int a, int b);
         if (dl[a] != dl[b]) return dl[a] < dl[b];
         if (arr[a] != arr[b]) return arr[a] < arr[b];
         return a < b;
      endfunction

      function int best_ready();
         int b;
         b = -1;
         for (int i = 0; i < 16; i++)
            if (ready[i] && (b < 0 || earlier(i, b))) b = i;
         return b;
      endfunction

      function void run_task(int t);
         ready[t] = 0; status[t] = ST_RUN; cpu = 1; cur = 4'(t);
      endfunction

      function bit try_preempt();
         int b;
         if (!cpu || ready == 0) return 0;
         b = best_ready();
         if (!(dl[b] < dl[cur])) return 0;
         status[cur] = ST_READY; ready[cur] = 1;
         run_task(b);
         return 1;
      endfunction

      function void note_word(logic [1:0] kind, logic [3:0] id, logic tv,
                              logic [15:0] p, logic [15:0] bg, logic [23:0] a,
                              logic [23:0] d, logic [23:0] now, logic sys,
                              logic [1:0] bt);
         sched_out_type o;
         int t;
         o = '0;
         case (kind)
            KIND_ADD: begin
               if (cpu && cur == id) cpu = 0;
               per[id] = p; bud[id] = bg; rem[id] = bg; arr[id] = a; dl[id] = d;
               status[id] = ST_READY; ready[id] = 1;
               o.preempted = try_preempt();
            end
            KIND_DISP: begin
               if (ready == 0 && !cpu) o.none_ready = 1;
               else begin
                  if (cpu) begin
                     status[cur] = ST_READY; ready[cur] = 1;
                  end
                  t = best_ready();
                  if (t >= 0) run_task(t);
               end
            end
            KIND_BLOCK: begin
               status[id] = ST_BLOCK; cnt[id] = bt; ready[id] = 0;
               if (cpu && cur == id) cpu = 0;
            end
            default: begin
               if (tv && status[id] == ST_BLOCK) begin
                  if (cnt[id] == 0) begin
                     status[id] = ST_READY; ready[id] = 1; o.unblocked = 1;
                  end else cnt[id]--;
               end
               for (int i = 0; i < 16; i++)
                  if (ready[i] && dl[i] < now) begin
                     o.missed_mask[i] = 1;
                     arr[i] = tsum(arr[i], per[i]);
                     dl[i] = tsum(arr[i], per[i]);
                     rem[i] = bud[i];
                  end
               o.preempted = try_preempt();
               if (cpu) begin
                  t = cur;
                  if (rem[t] > 0) rem[t]--;
                  if (rem[t] == 0 || sys) begin
                     status[t] = ST_IDLE; rem[t] = bud[t];
                     arr[t] = tsum(now, per[t]);
                     dl[t] = tsum(arr[t], per[t]);
                     cpu = 0;
                     o.completed = 1; o.completed_id = 4'(t);
                     o.next_arrival = arr[t]; o.next_deadline = dl[t];
                  end
               end
            end
         endcase
         o.running_valid = cpu;
         o.running_id = cpu ? cur : 4'd0;
         pending = {pending, o};
      endfunction

      task report(string what, longint got, longint want);
         $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      task check_word(sched_out_type g);
         sched_out_type e;
         if (pending.size() == 0) begin
            report("unexpected word", 64'(g), 0);
            return;
         end
         e = pending.pop_front();
         if (g.running_valid !== e.running_valid)
            report("running_valid", g.running_valid, e.running_valid);
         if (g.running_id !== e.running_id) report("running_id", g.running_id, e.running_id);
         if (g.none_ready !== e.none_ready) report("none_ready", g.none_ready, e.none_ready);
         if (g.preempted !== e.preempted) report("preempted", g.preempted, e.preempted);
         if (g.unblocked !== e.unblocked) report("unblocked", g.unblocked, e.unblocked);
         if (g.missed_mask !== e.missed_mask)
            report("missed_mask", g.missed_mask, e.missed_mask);
         if (g.completed !== e.completed) report("completed", g.completed, e.completed);
         if (g.completed_id !== e.completed_id)
            report("completed_id", g.completed_id, e.completed_id);
         if (g.next_arrival !== e.next_arrival)
            report("next_arrival", g.next_arrival, e.next_arrival);
         if (g.next_deadline !== e.next_deadline)
            report("next_deadline", g.next_deadline, e.next_deadline);
      endtask
   endclass

   logic          clock = 0;
   logic          reset = 1;
   logic          start = 0;
   logic          busy;
   logic [1:0]    req_kind = 0;
   logic [3:0]    req_task_id = 0;
   logic          req_task_valid = 0;
   logic [15:0]   req_period = 1;
   logic [15:0]   req_budget = 1;
   logic [23:0]   req_arrival_time = 0;
   logic [23:0]   req_deadline = 0;
   logic [23:0]   req_current_time = 0;
   logic          req_syscall_done = 0;
   logic [1:0]    req_block_ticks = 1;
   logic          rsp_valid;
   sched_out_type rsp;

   sched_board    board = new();
   bit            added [16];
   bit            quiet = 0;
   logic [23:0]   clk_now = 0;

   edf_task_scheduler u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_task_id(req_task_id), .req_task_valid(req_task_valid),
      .req_period(req_period), .req_budget(req_budget),
      .req_arrival_time(req_arrival_time), .req_deadline(req_deadline),
      .req_current_time(req_current_time), .req_syscall_done(req_syscall_done),
      .req_block_ticks(req_block_ticks), .rsp_valid(rsp_valid),
      .rsp_running_valid(rsp.running_valid), .rsp_running_id(rsp.running_id),
      .rsp_none_ready(rsp.none_ready), .rsp_preempted(rsp.preempted),
      .rsp_unblocked(rsp.unblocked), .rsp_missed_mask(rsp.missed_mask),
      .rsp_completed(rsp.completed), .rsp_completed_id(rsp.completed_id),
      .rsp_next_arrival(rsp.next_arrival), .rsp_next_deadline(rsp.next_deadline)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_word(rsp);
   end

   // Drive one word and wait until busy falls, then drop start.
   task automatic send_word(logic [1:0] k, logic [3:0] id, logic tv, logic [15:0] p,
                            logic [15:0] bg, logic [23:0] a, logic [23:0] d,
                            logic [23:0] now, logic sys, logic [1:0] bt);
      int gap;
      // a blocked task that was never added would be released with no timing
      if (k == KIND_ADD) added[id] = 1;
      if (k == KIND_BLOCK && !added[id]) k = KIND_DISP;
      start <= 1;
      req_kind <= k; req_task_id <= id; req_task_valid <= tv;
      req_period <= p; req_budget <= bg; req_arrival_time <= a;
      req_deadline <= d; req_current_time <= now; req_syscall_done <= sys;
      req_block_ticks <= bt;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_word(k, id, tv, p, bg, a, d, now, sys, bt);
      start <= 0;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         repeat (gap) @(posedge clock);
      end
      @(posedge clock);
   endtask

   task automatic rand_word(bit wide);
      logic [1:0]  k;
      logic [23:0] a;
      int          r;
      r = $urandom_range(0, 99);
      k = r < 25 ? KIND_ADD : r < 45 ? KIND_DISP : r < 55 ? KIND_BLOCK : KIND_TICK;
      if (wide) begin
         a = 24'($urandom);
         send_word(k, 4'($urandom), 1'($urandom), 16'($urandom_range(1, 65535)),
                   16'($urandom_range(1, 65535)), a, 24'($urandom), 24'($urandom),
                   1'($urandom), 2'($urandom_range(1, 3)));
      end else begin
         clk_now = clk_now + 24'($urandom_range(0, 6));
         a = clk_now + 24'($urandom_range(0, 4));
         send_word(k, 4'($urandom_range(0, 15)), $urandom_range(0, 3) != 0,
                   16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)), a,
                   a + 24'($urandom_range(1, 30)), clk_now, $urandom_range(0, 9) == 0,
                   2'($urandom_range(1, 3)));
      end
   endtask

   initial begin
      int tmo;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty dispatch, extremes, ties, preemption, block release, syscall
      send_word(KIND_DISP, 0, 0, 1, 1, 0, 0, 0, 0, 1);
      send_word(KIND_TICK, 5, 1, 1, 1, 0, 0, 24'hFFFFFF, 1, 1);
      send_word(KIND_ADD, 0, 0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 1);
      send_word(KIND_ADD, 15, 1, 1, 1, 0, 24'hFFFFFF, 0, 1, 3);
      send_word(KIND_DISP, 0, 0, 1, 1, 0, 0, 0, 0, 1);
      send_word(KIND_ADD, 3, 0, 5, 3, 0, 100, 0, 0, 1);
      send_word(KIND_ADD, 4, 0, 5, 3, 0, 100, 0, 0, 1);
      send_word(KIND_ADD, 2, 0, 5, 3, 10, 50, 0, 0, 1);
      send_word(KIND_DISP, 0, 0, 1, 1, 0, 0, 0, 0, 1);
      send_word(KIND_BLOCK, 4, 0, 1, 1, 0, 0, 0, 0, 3);
      send_word(KIND_BLOCK, 2, 0, 1, 1, 0, 0, 0, 0, 1);
      for (int i = 0; i < 5; i++) send_word(KIND_TICK, 4, 1, 1, 1, 0, 0, 60, 0, 1);
      send_word(KIND_TICK, 2, 1, 1, 1, 0, 0, 24'hFFFFFE, 0, 2);
      send_word(KIND_DISP, 0, 0, 1, 1, 0, 0, 0, 0, 1);
      send_word(KIND_TICK, 0, 0, 1, 1, 0, 0, 24'hFFFFFF, 1, 1);
      send_word(KIND_ADD, 3, 0, 1, 1, 0, 0, 0, 0, 1);
      send_word(KIND_DISP, 0, 0, 1, 1, 0, 0, 0, 0, 1);
      send_word(KIND_TICK, 0, 0, 1, 1, 0, 0, 1, 0, 1);
      // hold off until the block has drained everything
      tmo = 0;
      while (board.pending.size() != 0 && tmo < 1000) begin
         @(posedge clock);
         tmo++;
      end
      for (int n = 0; n < 1630; n++) begin
         if (n == 1450) quiet = 1;
         rand_word(n % 8 == 7);
      end
      tmo = 0;
      while (board.pending.size() != 0 && tmo < 2000) begin
         @(posedge clock);
         tmo++;
      end
      repeat (100) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
